// ===== design/smq_pkg.sv =====
// Shared types and constants of the service message queue.
// No dependencies; service_message_queue refers to it by scoped names.
`default_nettype none

package smq_pkg;

  localparam int MSG_BITS      = 64;
  localparam int COUNT_BITS    = 12;
  localparam int HANDLE_BITS   = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [COUNT_BITS-1:0] BASE_TH_RESET = 12'd1024;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_TAKE    = 2'd2,
    CMD_RELEASE = 2'd3
  } smq_cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_QUEUE_HANDLE   = 1'b0,
    CFG_BASE_THRESHOLD = 1'b1
  } smq_cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } smq_state_t;

  typedef struct packed {
    smq_cmd_t              cmd;
    logic [MSG_BITS-1:0]   push_word;
  } smq_in_t;

  typedef struct packed {
    logic                   pop_ok;
    logic [MSG_BITS-1:0]    pop_word;
    logic [COUNT_BITS-1:0]  fill_count;
    logic [COUNT_BITS-1:0]  overload_value;
    logic                   schedule_request;
    logic [HANDLE_BITS-1:0] request_handle;
    logic                   push_dropped;
  } smq_out_t;

endpackage

`default_nettype wire

// ===== design/smq_chan_if.sv =====
// Valid/ready channel carrying one item of payload type T.
// Depends on nothing; instantiated with smq_pkg struct types.
`default_nettype none

interface smq_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, input ready, output data);
  modport sink   (input valid, output ready, input data);
endinterface

`default_nettype wire

// ===== design/smq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module smq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/smq_thresh.sv =====
// Overload doubling: smallest max(live,1) << k not below the held count.
// No dependencies; used by service_message_queue.
`default_nettype none

module smq_thresh #(
  parameter int CNT_W = 12,
  parameter int TH_W  = 13
) (
  input  wire logic [CNT_W-1:0] held,
  input  wire logic [TH_W-1:0]  live,
  output logic                  need,
  output logic      [TH_W-1:0]  th_new
);

  localparam int EXT_W = TH_W + CNT_W;

  logic [TH_W-1:0]  th_base;
  logic [EXT_W-1:0] th_ext;
  logic [EXT_W-1:0] held_ext;
  logic [CNT_W:0]   hit;
  logic [CNT_W:0]   first;

  assign need = EXT_W'(held) > EXT_W'(live);

  // hit is a thermometer code; the lowest set bit picks the shift
  always_comb begin
    th_base  = (live == '0) ? TH_W'(1) : live;
    th_ext   = EXT_W'(th_base);
    held_ext = EXT_W'(held);
    for (int k = 0; k <= CNT_W; k++) begin
      hit[k] = (th_ext << k) >= held_ext;
    end
    first[0] = hit[0];
    for (int k = 1; k <= CNT_W; k++) begin
      first[k] = hit[k] & ~hit[k-1];
    end
    th_new = '0;
    for (int k = 0; k <= CNT_W; k++) begin
      if (first[k]) begin
        th_new = th_new | TH_W'(th_ext << k);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/service_message_queue.sv =====
// Top level of the service message queue: control, registers, result stage.
// Depends on smq_pkg, smq_chan_if, smq_ram and smq_thresh.
//
// Usage:
//   in_ch  (sink)   : one command item (push, pop, take overload, mark release)
//   out_ch (source) : exactly one result item per command item, in order
//   cfg_we/index/data: register writes (queue handle, base threshold), only
//                      while the queue is idle
// Timing:
//   Push, take, release and a pop on an empty queue write their result into
//   the output register at the edge that accepts them. A pop that delivers a
//   word goes through the registered read of the message RAM and the read
//   state first. One item is in flight at a time; the next item is accepted
//   in the same cycle the previous result is taken, so a full-rate receiver
//   sees one item per cycle except while a pop is in its read state.
// Reset (rst_n low, synchronous): empty queue, pointers zero, live threshold
//   1024, scheduled mark set, overload and release marks clear, handle 0.
//   RAM contents are not cleared; only pushed entries are ever read.
// Stall: while a result waits in the output register and out_ch.ready is low,
//   in_ch.ready is low and no state changes.
`default_nettype none

module service_message_queue #(
  parameter int QUEUE_DEPTH = 2048,
  parameter int WORD_BITS   = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  smq_chan_if.sink                                   in_ch,
  smq_chan_if.source                                 out_ch,
  input  wire logic                                  cfg_we,
  input  wire logic [smq_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [smq_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int FW    = smq_pkg::COUNT_BITS;
  localparam int HW    = smq_pkg::HANDLE_BITS;
  localparam int MW    = smq_pkg::MSG_BITS;
  localparam int TH_W  = ((CNT_W > FW) ? CNT_W : FW) + 1;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [AW-1:0]    LAST_PTR  = AW'(QUEUE_DEPTH - 1);

  // registers
  smq_pkg::smq_state_t state_r, state_nxt;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]    held_r, held_nxt;
  logic [TH_W-1:0]     live_th_r, live_th_nxt;
  logic [CNT_W-1:0]    lat_ovl_r, lat_ovl_nxt;
  logic                sched_r, sched_nxt;
  logic                release_r, release_nxt;
  logic [HW-1:0]       handle_r;
  logic [FW-1:0]       base_th_r;
  logic                out_valid_r, out_valid_nxt;
  smq_pkg::smq_out_t   out_data_r, out_data_nxt;

  // datapath
  logic                in_ready;
  logic                accept;
  logic                out_taken;
  logic [CNT_W-1:0]    held_dec;
  logic                th_need;
  logic [TH_W-1:0]     th_new;
  logic                ram_we;
  logic                ram_re;
  logic [WORD_BITS-1:0] ram_rdata;
  logic                req;

  assign in_ready      = (state_r == smq_pkg::ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready   = in_ready;
  assign accept        = in_ch.valid && in_ready;
  assign out_taken     = out_valid_r && out_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_data_r;
  assign held_dec      = held_r - CNT_W'(1);

  // Reads are issued only for entries written by an earlier item, and only
  // one item is in flight, so a read and a write never hit the same entry
  // in the same cycle.
  smq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (in_ch.data.push_word[WORD_BITS-1:0]),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // threshold check runs on the count after the pop
  smq_thresh #(
    .CNT_W (CNT_W),
    .TH_W  (TH_W)
  ) u_thresh (
    .held   (held_dec),
    .live   (live_th_r),
    .need   (th_need),
    .th_new (th_new)
  );

  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    held_nxt      = held_r;
    live_th_nxt   = live_th_r;
    lat_ovl_nxt   = lat_ovl_r;
    sched_nxt     = sched_r;
    release_nxt   = release_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_taken;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    req           = 1'b0;

    unique case (state_r)
      smq_pkg::ST_IDLE: begin
        if (accept) begin
          out_data_nxt  = '0;
          out_valid_nxt = 1'b1;
          unique case (in_ch.data.cmd)
            smq_pkg::CMD_PUSH: begin
              if (held_r >= DEPTH_CNT) begin
                out_data_nxt.push_dropped = 1'b1;
              end else begin
                ram_we     = 1'b1;
                wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
                held_nxt   = held_r + CNT_W'(1);
                if (!sched_r) begin
                  sched_nxt = 1'b1;
                  req       = 1'b1;
                end
              end
            end
            smq_pkg::CMD_POP: begin
              if (held_r != '0) begin
                // word arrives from the RAM next cycle
                ram_re                = 1'b1;
                out_valid_nxt         = 1'b0;
                state_nxt             = smq_pkg::ST_READ;
                out_data_nxt.pop_ok   = 1'b1;
                rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
                held_nxt   = held_dec;
                if (th_need) begin
                  live_th_nxt = th_new;
                  lat_ovl_nxt = held_dec;
                end
              end else begin
                live_th_nxt = TH_W'(base_th_r);
                sched_nxt   = 1'b0;
              end
            end
            smq_pkg::CMD_TAKE: begin
              out_data_nxt.overload_value = FW'(lat_ovl_r);
              lat_ovl_nxt                 = '0;
            end
            smq_pkg::CMD_RELEASE: begin
              release_nxt = 1'b1;
              req         = !sched_r;
            end
            default: ;
          endcase
          out_data_nxt.fill_count       = FW'(held_nxt);
          out_data_nxt.schedule_request = req;
          out_data_nxt.request_handle   = req ? handle_r : '0;
        end
      end
      smq_pkg::ST_READ: begin
        out_data_nxt.pop_word = MW'(ram_rdata);
        out_valid_nxt         = 1'b1;
        state_nxt             = smq_pkg::ST_IDLE;
      end
      default: state_nxt = smq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smq_pkg::ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      held_r      <= '0;
      live_th_r   <= TH_W'(smq_pkg::BASE_TH_RESET);
      lat_ovl_r   <= '0;
      sched_r     <= 1'b1;
      release_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      held_r      <= held_nxt;
      live_th_r   <= live_th_nxt;
      lat_ovl_r   <= lat_ovl_nxt;
      sched_r     <= sched_nxt;
      release_r   <= release_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      handle_r  <= '0;
      base_th_r <= smq_pkg::BASE_TH_RESET;
    end else if (cfg_we) begin
      unique case (smq_pkg::smq_cfg_idx_t'(cfg_index))
        smq_pkg::CFG_QUEUE_HANDLE:   handle_r  <= HW'(cfg_data);
        smq_pkg::CFG_BASE_THRESHOLD: base_th_r <= FW'(cfg_data);
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= DEPTH_CNT)
    else $error("held count above queue depth");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == smq_pkg::ST_READ |-> !out_valid_r)
    else $error("RAM read pending while result register occupied");

  a_full_push_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.data.cmd == smq_pkg::CMD_PUSH && held_r == DEPTH_CNT)
    |=> (held_r == DEPTH_CNT) && $stable(wr_ptr_r))
    else $error("dropped push changed queue state");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for service_message_queue: random and directed command items, with a
// self-contained queue predictor and an in-order check of every result item.
// Depends on smq_pkg, smq_chan_if and the service_message_queue RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH       = 2048;
  localparam int SLOT_BITS   = $clog2(DEPTH);
  localparam int QUIET_LIMIT = 1000;  // cycles with no handshake before giving up

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                              cfg_we;
  logic [smq_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [smq_pkg::CFG_DATA_BITS-1:0] cfg_data;

  smq_chan_if #(.T(smq_pkg::smq_in_t))  cmd_ch ();
  smq_chan_if #(.T(smq_pkg::smq_out_t)) res_ch ();

  service_message_queue #(
    .QUEUE_DEPTH(DEPTH),
    .WORD_BITS  (smq_pkg::MSG_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (cmd_ch),
    .out_ch   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the queue and its two registers.
  // ---------------------------------------------------------------------------
  logic [smq_pkg::MSG_BITS-1:0]    ring_copy [DEPTH];
  logic [SLOT_BITS-1:0]            rd_slot;
  logic [SLOT_BITS-1:0]            wr_slot;
  int                              held;         // messages in the queue
  int                              live_th;      // wide enough for any doubling
  logic [smq_pkg::COUNT_BITS-1:0]  latched_ovl;
  logic                            sched_mark;
  logic                            release_mark; // never visible at the outputs
  logic [smq_pkg::HANDLE_BITS-1:0] handle_reg;
  logic [smq_pkg::COUNT_BITS-1:0]  base_reg;

  smq_pkg::smq_in_t  cmd_backlog [$];      // items waiting for the driver
  smq_pkg::smq_out_t awaited_results [$];  // predicted results, oldest first
  int                mismatches   = 0;
  int                quiet_cycles = 0;

  // handshake bookkeeping shared between the posedge monitor and the drivers
  logic cmd_accepted = 1'b0;
  logic res_accepted = 1'b0;
  logic cmd_pending  = 1'b0;
  int   send_hold    = 0;
  int   sink_hold    = 0;
  logic idling_on    = 1'b1;

  // Applies one accepted command to the predictor and returns its result item.
  function automatic smq_pkg::smq_out_t predict_queue_result(smq_pkg::smq_in_t item);
    smq_pkg::smq_out_t r;
    int                th;
    r = '0;
    case (item.cmd)
      smq_pkg::CMD_PUSH: begin
        if (held >= DEPTH) begin
          // full queue: word lost, nothing else moves, no request
          r.push_dropped = 1'b1;
        end else begin
          ring_copy[wr_slot] = item.push_word;
          wr_slot++;
          held++;
          if (!sched_mark) begin
            sched_mark = 1'b1;
            r.schedule_request = 1'b1;
          end
        end
      end
      smq_pkg::CMD_POP: begin
        if (held != 0) begin
          r.pop_ok   = 1'b1;
          r.pop_word = ring_copy[rd_slot];
          rd_slot++;
          held--;
          if (held > live_th) begin
            // a zero threshold doubles as if it were one
            th = (live_th != 0) ? live_th : 1;
            while (held > th) th = th << 1;
            live_th     = th;
            latched_ovl = held[smq_pkg::COUNT_BITS-1:0];
          end
        end else begin
          live_th    = int'(base_reg);
          sched_mark = 1'b0;
        end
      end
      smq_pkg::CMD_TAKE: begin
        r.overload_value = latched_ovl;
        latched_ovl      = '0;
      end
      smq_pkg::CMD_RELEASE: begin
        release_mark = 1'b1;
        if (!sched_mark) r.schedule_request = 1'b1;
      end
    endcase
    r.fill_count     = held[smq_pkg::COUNT_BITS-1:0];
    r.request_handle = r.schedule_request ? handle_reg : '0;
    return r;
  endfunction

  function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_idle_len();
    int roll;
    roll = $urandom_range(99);
    if (!idling_on || roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [smq_pkg::MSG_BITS-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic void enqueue_cmd(smq_pkg::smq_cmd_t c,
                                      logic [smq_pkg::MSG_BITS-1:0] w);
    smq_pkg::smq_in_t item;
    item.cmd       = c;
    item.push_word = w;
    cmd_backlog.push_back(item);
  endfunction

  // Runs of pushes, runs of pops, and mixed runs that carry the take and
  // release commands. push_pct steers the fill level up or down.
  function automatic void queue_random_traffic(int n_items, int push_pct);
    int added;
    int run;
    int k;
    int pick;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(99);
      run  = $urandom_range(1, 10);
      for (k = 0; k < run; k++) begin
        if (pick < push_pct) enqueue_cmd(smq_pkg::CMD_PUSH, rand_word());
        else if (pick < 85) enqueue_cmd(smq_pkg::CMD_POP, rand_word());
        else enqueue_cmd(smq_pkg::smq_cmd_t'($urandom_range(3)), rand_word());
      end
      added += run;
    end
  endfunction

  // Sender holds off until every queued item has been answered.
  task automatic await_quiet_queue();
    while (cmd_backlog.size() != 0 || cmd_pending || awaited_results.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Register write; the predictor copy follows once the write has landed.
  task automatic write_register(smq_pkg::smq_cfg_idx_t idx,
                                logic [smq_pkg::CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == smq_pkg::CFG_QUEUE_HANDLE) handle_reg = value;
    else base_reg = value[smq_pkg::COUNT_BITS-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Command driver: presents backlog items on the falling edge, holds each one
  // until the rising edge that accepts it, then waits a random gap.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_pending && cmd_accepted) cmd_pending = 1'b0;
      if (!cmd_pending) begin
        if (send_hold > 0) begin
          send_hold--;
        end else if (cmd_backlog.size() != 0) begin
          cmd_ch.data <= cmd_backlog.pop_front();
          cmd_pending = 1'b1;
          send_hold   = pick_idle_len();
        end
      end
      cmd_ch.valid <= cmd_pending;
    end
  end

  // Result receiver: ready with random stalls of random length.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      sink_hold = pick_idle_len();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted command feeds the predictor; every accepted result
  // is checked against the oldest prediction. Also the stall watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    smq_pkg::smq_out_t want;
    smq_pkg::smq_out_t got;
    if (rst_n) begin
      cmd_accepted = cmd_ch.valid && cmd_ch.ready;
      res_accepted = res_ch.valid && res_ch.ready;
      if (cmd_accepted) awaited_results.push_back(predict_queue_result(cmd_ch.data));
      if (res_accepted) begin
        got = res_ch.data;
        if (awaited_results.size() == 0) begin
          $error("result item with no command waiting for it");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("pop_ok", 64'(want.pop_ok), 64'(got.pop_ok));
          compare_field("pop_word", want.pop_word, got.pop_word);
          compare_field("fill_count", 64'(want.fill_count), 64'(got.fill_count));
          compare_field("overload_value", 64'(want.overload_value),
                        64'(got.overload_value));
          compare_field("schedule_request", 64'(want.schedule_request),
                        64'(got.schedule_request));
          compare_field("request_handle", 64'(want.request_handle),
                        64'(got.request_handle));
          compare_field("push_dropped", 64'(want.push_dropped), 64'(got.push_dropped));
        end
      end
      if (cmd_accepted || res_accepted) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int                                ph;
    int                                k;
    int                                n;
    logic [smq_pkg::HANDLE_BITS-1:0]   handle;
    logic [smq_pkg::CFG_DATA_BITS-1:0] base;

    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    res_ch.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = smq_pkg::CFG_QUEUE_HANDLE;
    cfg_data     = '0;

    // predictor starts in the post-reset state
    rd_slot      = '0;
    wr_slot      = '0;
    held         = 0;
    base_reg     = smq_pkg::BASE_TH_RESET;
    live_th      = int'(smq_pkg::BASE_TH_RESET);
    latched_ovl  = '0;
    sched_mark   = 1'b1;
    release_mark = 1'b0;
    handle_reg   = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: scheduled mark set, nothing latched, handle zero.
    // Release on a scheduled queue, take with nothing latched, empty pop that
    // clears the mark, release marked twice (now raises a request), then the
    // first push after the empty pop raises one too; all-ones and zero words.
    enqueue_cmd(smq_pkg::CMD_RELEASE, rand_word());
    enqueue_cmd(smq_pkg::CMD_TAKE, rand_word());
    enqueue_cmd(smq_pkg::CMD_POP, rand_word());
    enqueue_cmd(smq_pkg::CMD_RELEASE, rand_word());
    enqueue_cmd(smq_pkg::CMD_PUSH, '1);
    enqueue_cmd(smq_pkg::CMD_PUSH, '0);
    enqueue_cmd(smq_pkg::CMD_RELEASE, rand_word());
    enqueue_cmd(smq_pkg::CMD_POP, rand_word());
    enqueue_cmd(smq_pkg::CMD_POP, rand_word());
    await_quiet_queue();

    // Smallest base threshold and an all-ones handle: overload latched on the
    // first pop that leaves more than one, then taken twice.
    write_register(smq_pkg::CFG_QUEUE_HANDLE, '1);
    write_register(smq_pkg::CFG_BASE_THRESHOLD, 1);
    enqueue_cmd(smq_pkg::CMD_POP, rand_word());
    for (k = 0; k < 3; k++) enqueue_cmd(smq_pkg::CMD_PUSH, rand_word());
    enqueue_cmd(smq_pkg::CMD_POP, rand_word());
    enqueue_cmd(smq_pkg::CMD_TAKE, rand_word());
    enqueue_cmd(smq_pkg::CMD_TAKE, rand_word());
    await_quiet_queue();

    // Base of 2048 fits the 12-bit register, so later pops stay at or below it.
    write_register(smq_pkg::CFG_QUEUE_HANDLE, 32'h5A5A_C3C3);
    write_register(smq_pkg::CFG_BASE_THRESHOLD, 2048);
    for (k = 0; k < 3; k++) enqueue_cmd(smq_pkg::CMD_POP, rand_word());
    enqueue_cmd(smq_pkg::CMD_PUSH, rand_word());
    enqueue_cmd(smq_pkg::CMD_PUSH, rand_word());
    enqueue_cmd(smq_pkg::CMD_POP, rand_word());
    enqueue_cmd(smq_pkg::CMD_TAKE, rand_word());

    for (ph = 0; ph < 7; ph++) begin
      if (ph == 3) begin
        // Burst pass at full rate: drain to empty with a small base, push a
        // long run, pause until the sender's backlog is answered, then drain
        // again so the threshold doubles several steps, with takes in between.
        await_quiet_queue();
        idling_on = 1'b0;
        write_register(smq_pkg::CFG_QUEUE_HANDLE, $urandom);
        write_register(smq_pkg::CFG_BASE_THRESHOLD, 4);
        n = held + 1;
        for (k = 0; k < n; k++) enqueue_cmd(smq_pkg::CMD_POP, rand_word());
        for (k = 0; k < 48; k++) enqueue_cmd(smq_pkg::CMD_PUSH, rand_word());
        enqueue_cmd(smq_pkg::CMD_RELEASE, rand_word());
        enqueue_cmd(smq_pkg::CMD_TAKE, rand_word());
        await_quiet_queue();
        for (k = 0; k < 49; k++) begin
          enqueue_cmd(smq_pkg::CMD_POP, rand_word());
          if (k == 5 || k == 24) enqueue_cmd(smq_pkg::CMD_TAKE, rand_word());
        end
      end

      await_quiet_queue();
      idling_on = (ph != 2);
      case (ph % 4)
        1:       handle = '0;
        2:       handle = '1;
        default: handle = $urandom;
      endcase
      case (ph)
        0:       base = 1;
        1:       base = 2048;
        2:       base = $urandom_range(2, 16);
        3:       base = smq_pkg::CFG_DATA_BITS'(smq_pkg::BASE_TH_RESET);
        4:       base = $urandom_range(1, 2048);
        5:       base = $urandom_range(1, 64);
        default: base = 2;
      endcase
      write_register(smq_pkg::CFG_QUEUE_HANDLE, handle);
      write_register(smq_pkg::CFG_BASE_THRESHOLD, base);
      queue_random_traffic(64, (ph % 2 == 0) ? 65 : 30);
    end

    await_quiet_queue();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
